// File: rtl/core/clf_pkg.sv
package clf_pkg;

    localparam int BUF_SIZE_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    localparam int TDATA_W = 16;

    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
    localparam logic [OP_W-1:0] OP_EOB   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic KIND_LINE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic              line_last;
        logic              accepted;
    } t_result;

    typedef struct packed {
        logic can_load;
        logic can_take;
    } t_stage_stat;

endpackage

// File: rtl/core/clf_out_stage.sv
module clf_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  clf_pkg::t_result     i_res,
    input  logic                 i_finish,
    output clf_pkg::t_stage_stat o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output clf_pkg::t_result     o_res,
    output logic                 o_run_last
);

    logic             r_ov, n_ov;
    logic             r_pv, n_pv;
    logic             r_rl, n_rl;
    clf_pkg::t_result r_out, n_out;
    clf_pkg::t_result r_pend, n_pend;

    assign o_stat.can_load = !r_ov || i_ready;
    assign o_stat.can_take = !r_pv || o_stat.can_load;

    always_comb begin
        n_ov   = r_ov;
        n_pv   = r_pv;
        n_rl   = r_rl;
        n_out  = r_out;
        n_pend = r_pend;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        if (i_push && i_finish) begin
            n_ov  = 1'b1;
            n_out = i_res;
            n_rl  = 1'b1;
        end else if (i_push) begin
            if (r_pv) begin
                n_ov  = 1'b1;
                n_out = r_pend;
                n_rl  = 1'b0;
            end
            n_pend = i_res;
            n_pv   = 1'b1;
        end else if (i_finish && r_pv) begin
            n_ov  = 1'b1;
            n_out = r_pend;
            n_rl  = 1'b1;
            n_pv  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_pv <= n_pv;
        end
        r_rl   <= n_rl;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_valid    = r_ov;
    assign o_res      = r_out;
    assign o_run_last = r_rl;

endmodule

// File: rtl/core/crlf_line_framer.sv
// A chunk status is registered and appears on the output in the cycle after its last byte.
// End of burst: each stored byte is scanned (read, then checked), each emitted byte is read,
// then put, each line ends with a check, and each byte moved to the front is read, then written;
// a finish step and any output stalls add to it; input stalls until it ends.
// Throughput: one byte per cycle in idle when not stalled (single buffer write port).
// Reset: synchronous active-low; clears counts, flags and output valid; buffer unchanged.
module crlf_line_framer #(
    parameter int BUF_SIZE = clf_pkg::BUF_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [clf_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [clf_pkg::OP_W-1:0]    s_axis_tuser,   // [1:0] op
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [clf_pkg::TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [8] line_last,
                                                        // [9] accepted, [15:10] zero
    output logic                        m_axis_tuser,   // [0] kind
    output logic                        m_axis_tlast
);

    localparam int AW = $clog2(BUF_SIZE);
    localparam int CW = $clog2(BUF_SIZE + 1);
    localparam logic [CW-1:0] BUF_LIM = CW'(BUF_SIZE);
    localparam logic [CW-1:0] ONE     = CW'(1);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SCAN_RD  = 8'b0000_0010,
        ST_SCAN_CHK = 8'b0000_0100,
        ST_EMIT_RD  = 8'b0000_1000,
        ST_EMIT_PUT = 8'b0001_0000,
        ST_COPY_RD  = 8'b0010_0000,
        ST_COPY_WR  = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } t_state;

    logic [clf_pkg::BYTE_W-1:0] line_mem [BUF_SIZE];
    logic [clf_pkg::BYTE_W-1:0] r_rdata;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_fill, n_fill;
    logic [CW-1:0]              r_comm, n_comm;
    logic                       r_ovf, n_ovf;
    logic                       r_seen, n_seen;
    logic [CW-1:0]              r_len, n_len;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_start, n_start;
    logic [CW-1:0]              r_eidx, n_eidx;
    logic [CW-1:0]              r_end, n_end;
    logic [clf_pkg::BYTE_W-1:0] r_prev, n_prev;
    logic                       r_saw, n_saw;
    logic                       r_raw, n_raw;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [clf_pkg::BYTE_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;

    logic                       push;
    logic                       finish;
    clf_pkg::t_result           push_res;
    clf_pkg::t_stage_stat       stat;
    clf_pkg::t_result           out_res;
    logic                       out_rl;

    always_comb begin
        logic          store;
        logic          ok;
        logic [CW-1:0] fill_inc;
        logic [CW-1:0] line_end;
        logic [CW-1:0] cp_dst;

        n_state   = r_state;
        n_fill    = r_fill;
        n_comm    = r_comm;
        n_ovf     = r_ovf;
        n_seen    = r_seen;
        n_len     = r_len;
        n_idx     = r_idx;
        n_start   = r_start;
        n_eidx    = r_eidx;
        n_end     = r_end;
        n_prev    = r_prev;
        n_saw     = r_saw;
        n_raw     = r_raw;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        push      = 1'b0;
        finish    = 1'b0;
        push_res  = '0;
        s_axis_tready = 1'b0;

        store    = r_fill < BUF_LIM;
        fill_inc = r_fill + ONE;
        ok       = !r_ovf && store && (fill_inc < BUF_LIM);
        line_end = ((r_idx > r_start) && (r_prev == clf_pkg::CH_CR)) ? r_idx - ONE : r_idx;
        cp_dst   = r_idx - r_start;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = stat.can_load;
                if (s_axis_tvalid && stat.can_load) begin
                    unique case (s_axis_tuser)
                        clf_pkg::OP_DATA: begin
                            if (store) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_fill[AW-1:0];
                                mem_wdata = s_axis_tdata;
                                n_fill    = fill_inc;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (s_axis_tlast) begin
                                push              = 1'b1;
                                finish            = 1'b1;
                                push_res.kind     = clf_pkg::KIND_STATUS;
                                push_res.accepted = ok;
                                n_ovf             = 1'b0;
                                if (ok) begin
                                    n_comm = fill_inc;
                                end else begin
                                    n_fill = r_comm;
                                end
                            end
                        end
                        clf_pkg::OP_EOB: begin
                            n_fill = r_comm;
                            n_ovf  = 1'b0;
                            if (r_comm != '0) begin
                                n_len   = r_comm;
                                n_idx   = '0;
                                n_start = '0;
                                n_saw   = 1'b0;
                                n_raw   = 1'b0;
                                n_state = ST_SCAN_RD;
                            end
                        end
                        clf_pkg::OP_CLEAR: begin
                            n_fill = '0;
                            n_comm = '0;
                            n_ovf  = 1'b0;
                            n_seen = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                if (r_idx == r_len) begin
                    if (r_saw) begin
                        n_seen = 1'b1;
                        n_comm = r_len - r_start;
                        n_fill = r_len - r_start;
                        if ((r_start != '0) && (r_len != r_start)) begin
                            n_idx   = r_start;
                            n_state = ST_COPY_RD;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end else if (r_seen) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_eidx  = '0;
                        n_end   = r_len;
                        n_raw   = 1'b1;
                        n_state = ST_EMIT_RD;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_state   = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                n_idx = r_idx + ONE;
                if (r_rdata == clf_pkg::CH_LF) begin
                    n_saw   = 1'b1;
                    n_start = r_idx + ONE;
                    if (line_end > r_start) begin
                        n_eidx  = r_start;
                        n_end   = line_end;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_state = ST_SCAN_RD;
                    end
                end else begin
                    n_prev  = r_rdata;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                if (r_eidx == r_end) begin
                    if (r_raw) begin
                        n_comm  = '0;
                        n_fill  = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN_RD;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_eidx[AW-1:0];
                    n_state   = ST_EMIT_PUT;
                end
            end
            ST_EMIT_PUT: begin
                if (stat.can_take) begin
                    push               = 1'b1;
                    push_res.kind      = clf_pkg::KIND_LINE;
                    push_res.data      = r_rdata;
                    push_res.line_last = (r_eidx + ONE) == r_end;
                    n_eidx             = r_eidx + ONE;
                    n_state            = ST_EMIT_RD;
                end
            end
            ST_COPY_RD: begin
                if (r_idx == r_len) begin
                    n_state = ST_FINISH;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_state   = ST_COPY_WR;
                end
            end
            ST_COPY_WR: begin
                mem_we    = 1'b1;
                mem_waddr = cp_dst[AW-1:0];
                mem_wdata = r_rdata;
                n_idx     = r_idx + ONE;
                n_state   = ST_COPY_RD;
            end
            ST_FINISH: begin
                if (stat.can_take) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= line_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_comm  <= '0;
            r_ovf   <= 1'b0;
            r_seen  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_comm  <= n_comm;
            r_ovf   <= n_ovf;
            r_seen  <= n_seen;
        end
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_start <= n_start;
        r_eidx  <= n_eidx;
        r_end   <= n_end;
        r_prev  <= n_prev;
        r_saw   <= n_saw;
        r_raw   <= n_raw;
    end

    clf_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res      (push_res),
        .i_finish   (finish),
        .o_stat     (stat),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (out_res),
        .o_run_last (out_rl)
    );

    assign m_axis_tdata = {(clf_pkg::TDATA_W - clf_pkg::BYTE_W - 2)'(0),
                           out_res.accepted, out_res.line_last, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_rl;

endmodule

// File: rtl/core/clf_checker.sv
module clf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [clf_pkg::BYTE_W-1:0]  s_axis_tdata,
    input logic [clf_pkg::OP_W-1:0]    s_axis_tuser,
    input logic                        s_axis_tlast,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [clf_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                        m_axis_tuser,
    input logic                        m_axis_tlast
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == clf_pkg::KIND_STATUS)
            |-> (m_axis_tlast && m_axis_tdata[clf_pkg::BYTE_W:0] == '0))
        else $error("malformed chunk status");

    a_run_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == clf_pkg::KIND_LINE && m_axis_tlast)
            |-> (m_axis_tdata[clf_pkg::BYTE_W] && !m_axis_tdata[clf_pkg::BYTE_W+1]))
        else $error("burst ends inside a line");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output transaction changed");

endmodule

bind crlf_line_framer clf_checker u_clf_checker (.*);
